// File: sv/sps_pkg.sv
// Package: shared types and constants for the segment point sampler.
`timescale 1ns / 1ps
package sps_pkg;
  localparam int CoordWidth = 16;
  localparam int Capacity   = 1024;
  localparam int MaxPoints  = 64;
  localparam int MinPoints  = 3;
  localparam int SlotWidth  = 10;
  localparam int CountWidth = 11;
  localparam int SpaceWidth = 15;
  localparam logic [SpaceWidth-1:0] SpacingReset = 15'd51;

  // Datapath widths: axis difference, squared length, divider dividend
  localparam int DiffWidth = CoordWidth + 1;
  localparam int SqWidth   = 2 * DiffWidth;
  localparam int DivWidth  = CoordWidth + 6;
  localparam int StepWidth = 5;
  localparam int NWidth    = 7;
  localparam int IdxWidth  = 6;

  localparam logic [1:0] KIND_SEGMENT = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]                   kind;
    logic                         list_select;
    logic signed [CoordWidth-1:0] x_start;
    logic signed [CoordWidth-1:0] y_start;
    logic signed [CoordWidth-1:0] x_end;
    logic signed [CoordWidth-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic                         list_tag;
    logic [SlotWidth-1:0]         slot;
    logic                         stored;
    logic                         last;
  } out_item_t;
endpackage

// File: sv/segment_point_sampler.sv
// Top level: segment to evenly spaced point sampler with list slot allocation.
//
// Items enter on in_valid/in_ready with an in_item_t payload; points leave on
// out_valid/out_ready as out_item_t, last set on the final point of an item.
// cfg_we/cfg_wdata write point_spacing (0 acts as 1); write only while idle.
// One multiplier and one restoring divider are shared under a sequencer.
// Segment: the x and y squares, the square root (one root bit a cycle), the
// count division, then per point: one product and one division per axis plus
// one emit, which waits out any output stall. The block is back in idle after
// the last of the N points (N from 3 to 64).
// Single point: the sequencer goes straight to its emit state. Clear: no result.
// The block takes one item at a time; in_ready is high only while idle.
// A point waits in the output register while the receiver stalls; the next
// point is computed meanwhile and the sequencer holds in its emit cycle
// until the register is free.
// Reset (synchronous, rst_n low) empties both lists, restores spacing 51 and
// drops any item in flight.
`timescale 1ns / 1ps
module segment_point_sampler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sps_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sps_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [sps_pkg::SpaceWidth-1:0] cfg_wdata
);
  import sps_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_NDIV = 4'd4;
  localparam logic [3:0] S_MULX = 4'd5;
  localparam logic [3:0] S_XDIV = 4'd6;
  localparam logic [3:0] S_MULY = 4'd7;
  localparam logic [3:0] S_YDIV = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]                   state_r, state_nxt;
  logic [SpaceWidth-1:0]        spacing_r;
  logic [CountWidth-1:0]        scount_r, dcount_r;
  in_item_t                     item_r;
  logic [DiffWidth-1:0]         ax_r, ay_r;
  logic                         sx_r, sy_r;
  logic [SqWidth-1:0]           sq_r;
  logic [DiffWidth-1:0]         root_r;
  logic [StepWidth-1:0]         step_r;
  logic [NWidth-1:0]            n_r;
  logic [IdxWidth-1:0]          idx_r;
  logic [DivWidth-1:0]          dvd_r, quo_r;
  logic [DiffWidth-1:0]         rem_r, dvs_r;
  logic signed [CoordWidth-1:0] px_r, py_r;
  logic                         ov_r;
  out_item_t                    od_r;

  logic                         accept, emit_go, is_last, root_take;
  logic signed [DiffWidth-1:0]  dx_in, dy_in;
  logic [DiffWidth-1:0]         ax_in, ay_in;
  logic [DiffWidth-1:0]         cand, mul_a, mul_b;
  logic [SqWidth-1:0]           prod;
  logic [DiffWidth:0]           rem_sh;
  logic                         ge;
  logic [DiffWidth-1:0]         rem_nxt;
  logic [DivWidth-1:0]          quo_nxt;
  logic [CoordWidth-1:0]        q_mag;
  logic [NWidth-1:0]            nclamp;
  logic [CountWidth-1:0]        cnt_sel;
  logic [SpaceWidth-1:0]        sp_eff;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Axis differences and magnitudes of the incoming segment
  assign dx_in = {in_data.x_end[CoordWidth-1], in_data.x_end}
               - {in_data.x_start[CoordWidth-1], in_data.x_start};
  assign dy_in = {in_data.y_end[CoordWidth-1], in_data.y_end}
               - {in_data.y_start[CoordWidth-1], in_data.y_start};
  assign ax_in = dx_in[DiffWidth-1] ? DiffWidth'(-dx_in) : dx_in;
  assign ay_in = dy_in[DiffWidth-1] ? DiffWidth'(-dy_in) : dy_in;

  // Shared multiplier: squares, root candidates and interpolation products
  assign cand = root_r | (DiffWidth'(1) << step_r);
  always_comb begin
    case (state_r)
      S_SQX: begin
        mul_a = ax_r;
        mul_b = ax_r;
      end
      S_SQY: begin
        mul_a = ay_r;
        mul_b = ay_r;
      end
      S_SQRT: begin
        mul_a = cand;
        mul_b = cand;
      end
      S_MULX: begin
        mul_a = ax_r;
        mul_b = DiffWidth'(idx_r);
      end
      S_MULY: begin
        mul_a = ay_r;
        mul_b = DiffWidth'(idx_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod      = SqWidth'(mul_a) * SqWidth'(mul_b);
  assign root_take = (prod <= sq_r);

  // Shared restoring divider step: one quotient bit a cycle
  assign rem_sh  = {rem_r, dvd_r[DivWidth-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt = ge ? DiffWidth'(rem_sh - {1'b0, dvs_r}) : rem_sh[DiffWidth-1:0];
  assign quo_nxt = {quo_r[DivWidth-2:0], ge};
  assign q_mag   = quo_nxt[CoordWidth-1:0];

  // Clamp the point count between the minimum and the maximum
  always_comb begin
    if (quo_nxt > DivWidth'(MaxPoints)) nclamp = NWidth'(MaxPoints);
    else if (quo_nxt < DivWidth'(MinPoints)) nclamp = NWidth'(MinPoints);
    else nclamp = quo_nxt[NWidth-1:0];
  end

  assign sp_eff  = (spacing_r == '0) ? SpaceWidth'(1) : spacing_r;
  assign cnt_sel = item_r.list_select ? dcount_r : scount_r;
  assign emit_go = (state_r == S_EMIT) && (!ov_r || out_ready);
  assign is_last = ({1'b0, idx_r} == n_r - NWidth'(1));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        case (in_data.kind)
          KIND_SEGMENT: state_nxt = S_SQX;
          KIND_POINT:   state_nxt = S_EMIT;
          default:      state_nxt = S_IDLE;
        endcase
      end
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SQRT;
      S_SQRT: if (step_r == '0) state_nxt = S_NDIV;
      S_NDIV: if (step_r == '0) state_nxt = S_MULX;
      S_MULX: state_nxt = S_XDIV;
      S_XDIV: if (step_r == '0) state_nxt = S_MULY;
      S_MULY: state_nxt = S_YDIV;
      S_YDIV: if (step_r == '0) state_nxt = S_EMIT;
      S_EMIT: if (emit_go) state_nxt = is_last ? S_IDLE : S_MULX;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers, spacing and list counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      spacing_r <= SpacingReset;
      scount_r  <= '0;
      dcount_r  <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) spacing_r <= cfg_wdata;
      if (emit_go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (accept && in_data.kind == KIND_CLEAR) dcount_r <= '0;
      if (emit_go && cnt_sel < CountWidth'(Capacity)) begin
        if (item_r.list_select) dcount_r <= cnt_sel + CountWidth'(1);
        else                    scount_r <= cnt_sel + CountWidth'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (accept) begin
        item_r <= in_data;
        ax_r   <= ax_in;
        ay_r   <= ay_in;
        sx_r   <= dx_in[DiffWidth-1];
        sy_r   <= dy_in[DiffWidth-1];
        px_r   <= in_data.x_start;
        py_r   <= in_data.y_start;
        n_r    <= NWidth'(1);
        idx_r  <= '0;
      end
      S_SQX: sq_r <= prod;
      S_SQY: begin
        sq_r   <= sq_r + prod;
        root_r <= '0;
        step_r <= StepWidth'(DiffWidth - 1);
      end
      S_SQRT: begin
        // Keep the candidate bit when its square still fits
        if (root_take) root_r <= cand;
        if (step_r == '0) begin
          dvd_r  <= DivWidth'(root_take ? cand : root_r);
          dvs_r  <= DiffWidth'(sp_eff);
          rem_r  <= '0;
          quo_r  <= '0;
          step_r <= StepWidth'(DivWidth - 1);
        end else begin
          step_r <= step_r - StepWidth'(1);
        end
      end
      S_NDIV, S_XDIV, S_YDIV: begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        dvd_r  <= dvd_r << 1;
        step_r <= step_r - StepWidth'(1);
        if (step_r == '0) begin
          case (state_r)
            S_NDIV: begin
              n_r   <= nclamp;
              idx_r <= '0;
            end
            S_XDIV: px_r <= sx_r ? item_r.x_start - $signed(q_mag)
                                 : item_r.x_start + $signed(q_mag);
            S_YDIV: py_r <= sy_r ? item_r.y_start - $signed(q_mag)
                                 : item_r.y_start + $signed(q_mag);
            default: ;
          endcase
        end
      end
      S_MULX, S_MULY: begin
        // Load magnitude times index over count minus one
        dvd_r  <= prod[DivWidth-1:0];
        dvs_r  <= DiffWidth'(n_r - NWidth'(1));
        rem_r  <= '0;
        quo_r  <= '0;
        step_r <= StepWidth'(DivWidth - 1);
      end
      S_EMIT: if (emit_go) begin
        od_r.point_x  <= px_r;
        od_r.point_y  <= py_r;
        od_r.list_tag <= item_r.list_select;
        od_r.last     <= is_last;
        if (cnt_sel < CountWidth'(Capacity)) begin
          od_r.slot   <= cnt_sel[SlotWidth-1:0];
          od_r.stored <= 1'b1;
        end else begin
          od_r.slot   <= '0;
          od_r.stored <= 1'b0;
        end
        if (!is_last) idx_r <= idx_r + IdxWidth'(1);
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule
